[sv/adcb_pkg.sv]
// Shared types and constants for the adaptive decimating capture buffer.
// Used by adcb_ctrl, adcb_datapath and the top level; no dependencies.

package adcb_pkg;

    // Saturation limits of the index and stride counters
    localparam logic [31:0] IDX_MAX          = 32'hFFFF_FFFF;
    localparam logic [31:0] STRIDE_CAP       = 32'h8000_0000;
    // Any stride at or above this would pass the cap when doubled
    localparam logic [31:0] STRIDE_DBL_LIMIT = 32'h4000_0001;

    // Initial stride is this many times the sample rate
    localparam logic [31:0] STRIDE_MULT      = 32'd5;

    // Reset values
    localparam logic [7:0]  RATE_RESET       = 8'd1;
    localparam logic [31:0] STRIDE_RESET     = 32'd5;
    localparam logic [31:0] INDEX_RESET      = 32'd1;

    // Action codes
    localparam logic ACT_OFFER = 1'b0;
    localparam logic ACT_READ  = 1'b1;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic load_item;    // latch the accepted item, start the read of the store
        logic eval_commit;  // commit session restart values
        logic eval_bump;    // also advance the sample index (sample not due)
        logic cmp_read;     // compaction: read source entry
        logic cmp_write;    // compaction: write entry to destination
        logic append;       // store the speed, advance indices
        logic load_result;  // load the output registers
    } dp_cmd_t;

    // Status from the datapath to the controller
    typedef struct packed {
        logic is_read;      // latched item is a read
        logic due;          // latched offer is due for storing
        logic full;         // store is full (with session restart applied)
        logic cmp_last;     // compaction is on its last entry
    } dp_status_t;

endpackage

[sv/adaptive_decimating_capture_buffer_core.sv]
// Top level of the adaptive decimating capture buffer.
// Instantiates adcb_ctrl and adcb_datapath; uses adcb_pkg.
//
//  channel   | handshake                   | payload
//  ----------+-----------------------------+------------------------------------------
//  config    | cfg_write_en                | cfg_write_data (sample rate)
//  sample in | sample_valid / sample_stall | action, speed, first, read_index
//  result    | result_valid / result_stall | entry_value, entry_valid, point_count,
//            |                             | stride, samples_seen
//
// A read, or an offer that is not kept, passes through evaluation and finish before the next accept.
// A kept offer also passes through append; when the store is full it first runs a compaction
// over ceil(MAX_POINTS / 2) entries (one read, then one write per entry).
// Reset clears all counters at once; the store itself needs no clearing pass.
// A stalled result sits in the output register while the next item is accepted;
// that item then waits in its last cycle until the output register frees.

module adaptive_decimating_capture_buffer_core #(
    parameter int MAX_POINTS = 256,
    parameter int SPEED_BITS = 16
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_write_en,
    input  logic [7:0]                      cfg_write_data,
    input  logic                            sample_valid,
    output logic                            sample_stall,
    input  logic                            action,
    input  logic [SPEED_BITS-1:0]           speed,
    input  logic                            first,
    input  logic [7:0]                      read_index,
    output logic                            result_valid,
    input  logic                            result_stall,
    output logic [SPEED_BITS-1:0]           entry_value,
    output logic                            entry_valid,
    output logic [$clog2(MAX_POINTS+1)-1:0] point_count,
    output logic [31:0]                     stride,
    output logic [31:0]                     samples_seen
);
    import adcb_pkg::*;

    dp_cmd_t    cmd;
    dp_status_t status;

    adcb_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .sample_valid (sample_valid),
        .sample_stall (sample_stall),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .status       (status),
        .cmd          (cmd)
    );

    adcb_datapath #(
        .MAX_POINTS (MAX_POINTS),
        .SPEED_BITS (SPEED_BITS)
    ) u_datapath (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_write_en   (cfg_write_en),
        .cfg_write_data (cfg_write_data),
        .action         (action),
        .speed          (speed),
        .first          (first),
        .read_index     (read_index),
        .cmd            (cmd),
        .status         (status),
        .entry_value    (entry_value),
        .entry_valid    (entry_valid),
        .point_count    (point_count),
        .stride         (stride),
        .samples_seen   (samples_seen)
    );

endmodule

[sv/adcb_ctrl.sv]
// Controller state machine for the adaptive decimating capture buffer.
// Depends on adcb_pkg (command and status structs).

module adcb_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 sample_valid,
    output logic                 sample_stall,
    output logic                 result_valid,
    input  logic                 result_stall,
    input  adcb_pkg::dp_status_t status,
    output adcb_pkg::dp_cmd_t    cmd
);
    import adcb_pkg::*;

    typedef enum logic [5:0] {
        ST_IDLE   = 6'b000001,
        ST_EVAL   = 6'b000010,
        ST_CMP_RD = 6'b000100,
        ST_CMP_WR = 6'b001000,
        ST_APPEND = 6'b010000,
        ST_FINISH = 6'b100000
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   valid_reg;
    logic   valid_next;
    logic   accept;
    logic   out_free;

    assign accept       = sample_valid && (state_reg == ST_IDLE);
    assign out_free     = !valid_reg || !result_stall;
    assign sample_stall = (state_reg != ST_IDLE);
    assign result_valid = valid_reg;

    // Next state and datapath commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    cmd.load_item = 1'b1;
                    state_next    = ST_EVAL;
                end
            end
            ST_EVAL:
            begin
                if (status.is_read)
                begin
                    state_next = ST_FINISH;
                end
                else if (!status.due)
                begin
                    cmd.eval_commit = 1'b1;
                    cmd.eval_bump   = 1'b1;
                    state_next      = ST_FINISH;
                end
                else
                begin
                    cmd.eval_commit = 1'b1;
                    state_next      = status.full ? ST_CMP_RD : ST_APPEND;
                end
            end
            ST_CMP_RD:
            begin
                cmd.cmp_read = 1'b1;
                state_next   = ST_CMP_WR;
            end
            ST_CMP_WR:
            begin
                cmd.cmp_write = 1'b1;
                state_next    = status.cmp_last ? ST_APPEND : ST_CMP_RD;
            end
            ST_APPEND:
            begin
                cmd.append = 1'b1;
                state_next = ST_FINISH;
            end
            ST_FINISH:
            begin
                if (out_free)
                begin
                    cmd.load_result = 1'b1;
                    state_next      = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Output valid flag
    always_comb
    begin
        valid_next = valid_reg;
        if (cmd.load_result)
        begin
            valid_next = 1'b1;
        end
        else if (valid_reg && !result_stall)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            valid_reg <= valid_next;
        end
    end

`ifndef SYNTHESIS
    a_accept_to_eval: assert property (@(posedge clk) disable iff (!rst_n)
        (sample_valid && !sample_stall) |=> (state_reg == ST_EVAL))
        else $error("accepted item did not move to evaluation");

    a_cmp_end_appends: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_CMP_WR && status.cmp_last) |=> (state_reg == ST_APPEND))
        else $error("compaction end did not lead to append");

    a_finish_waits: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_FINISH && valid_reg && result_stall) |=> (state_reg == ST_FINISH))
        else $error("result overwritten while output stalled");
`endif

endmodule

[sv/adcb_datapath.sv]
// Datapath of the adaptive decimating capture buffer: point store, counters,
// session state and output registers. Depends on adcb_pkg.

module adcb_datapath #(
    parameter int MAX_POINTS = 256,
    parameter int SPEED_BITS = 16
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_write_en,
    input  logic [7:0]                          cfg_write_data,
    input  logic                                action,
    input  logic [SPEED_BITS-1:0]               speed,
    input  logic                                first,
    input  logic [7:0]                          read_index,
    input  adcb_pkg::dp_cmd_t                   cmd,
    output adcb_pkg::dp_status_t                status,
    output logic [SPEED_BITS-1:0]               entry_value,
    output logic                                entry_valid,
    output logic [$clog2(MAX_POINTS+1)-1:0]     point_count,
    output logic [31:0]                         stride,
    output logic [31:0]                         samples_seen
);
    import adcb_pkg::*;

    localparam int AW   = $clog2(MAX_POINTS);
    localparam int CW   = $clog2(MAX_POINTS + 1);
    localparam int IW   = (CW > 8) ? CW : 8;
    localparam int HALF = (MAX_POINTS + 1) / 2;

    // Point store
    logic [SPEED_BITS-1:0] mem [MAX_POINTS];
    logic [SPEED_BITS-1:0] rdata_reg;

    // Session state
    logic [7:0]            rate_reg,   rate_next;
    logic [CW-1:0]         held_reg,   held_next;
    logic [31:0]           stride_reg, stride_next;
    logic [31:0]           due_reg,    due_next;
    logic [31:0]           sidx_reg,   sidx_next;
    logic [AW-1:0]         dst_reg,    dst_next;

    // Latched item
    logic                  act_reg,    act_next;
    logic                  first_reg,  first_next;
    logic [SPEED_BITS-1:0] speed_reg,  speed_next;
    logic [7:0]            ridx_reg,   ridx_next;

    // Output registers
    logic [SPEED_BITS-1:0] value_reg,  value_next;
    logic                  hit_reg,    hit_next;
    logic [CW-1:0]         cnt_reg,    cnt_next;
    logic [31:0]           ostr_reg,   ostr_next;
    logic [31:0]           seen_reg,   seen_next;

    // Helpers
    logic [7:0]            rate_eff;
    logic [31:0]           init_stride;
    logic                  sess;
    logic [CW-1:0]         eff_held;
    logic [31:0]           eff_stride;
    logic [31:0]           eff_due;
    logic [31:0]           eff_sidx;
    logic [32:0]           due_sum;
    logic [31:0]           due_sat;
    logic [31:0]           stride_dbl;
    logic                  cmp_last;
    logic [IW-1:0]         rd_ext;
    logic [AW:0]           two_dst;
    logic                  rd_hit;
    logic                  mem_we;
    logic                  mem_re;
    logic [AW-1:0]         waddr;
    logic [AW-1:0]         raddr;
    logic [SPEED_BITS-1:0] wdata;

    // Initial stride from the rate, zero rate counts as one
    assign rate_eff    = (rate_reg == 8'd0) ? 8'd1 : rate_reg;
    assign init_stride = 32'(rate_eff) * STRIDE_MULT;

    // Values seen by the offer once a session restart is applied
    assign sess       = (act_reg == ACT_OFFER) && first_reg;
    assign eff_held   = sess ? '0 : held_reg;
    assign eff_stride = sess ? init_stride : stride_reg;
    assign eff_due    = sess ? INDEX_RESET : due_reg;
    assign eff_sidx   = sess ? INDEX_RESET : sidx_reg;

    // Saturating next due index and stride doubling
    assign due_sum    = {1'b0, sidx_reg} + {1'b0, stride_reg};
    assign due_sat    = due_sum[32] ? IDX_MAX : due_sum[31:0];
    assign stride_dbl = (stride_reg >= STRIDE_DBL_LIMIT) ? STRIDE_CAP
                                                         : {stride_reg[30:0], 1'b0};

    assign cmp_last = (dst_reg == AW'(HALF - 1));

    assign status.is_read  = (act_reg == ACT_READ);
    assign status.due      = (act_reg == ACT_OFFER) && (eff_sidx != IDX_MAX)
                             && (eff_sidx >= eff_due);
    assign status.full     = (eff_held == CW'(MAX_POINTS));
    assign status.cmp_last = cmp_last;

    // Store addressing: reads for a read item or a compaction source,
    // writes for an append or a compaction destination
    assign rd_ext  = IW'(read_index);
    assign two_dst = {dst_reg, 1'b0};
    assign mem_re  = cmd.load_item || cmd.cmp_read;
    assign raddr   = cmd.load_item ? rd_ext[AW-1:0] : two_dst[AW-1:0];
    assign mem_we  = cmd.append || cmd.cmp_write;
    assign waddr   = cmd.append ? held_reg[AW-1:0] : dst_reg;
    assign wdata   = cmd.append ? speed_reg : rdata_reg;

    assign rd_hit = (act_reg == ACT_READ) && (IW'(ridx_reg) < IW'(held_reg));

    // Next-state logic
    always_comb
    begin
        rate_next   = rate_reg;
        held_next   = held_reg;
        stride_next = stride_reg;
        due_next    = due_reg;
        sidx_next   = sidx_reg;
        dst_next    = dst_reg;
        act_next    = act_reg;
        first_next  = first_reg;
        speed_next  = speed_reg;
        ridx_next   = ridx_reg;
        value_next  = value_reg;
        hit_next    = hit_reg;
        cnt_next    = cnt_reg;
        ostr_next   = ostr_reg;
        seen_next   = seen_reg;

        if (cfg_write_en)
        begin
            rate_next = cfg_write_data;
        end

        if (cmd.load_item)
        begin
            act_next   = action;
            first_next = first;
            speed_next = speed;
            ridx_next  = read_index;
        end

        // Session restart, and index advance for a sample that is not kept
        if (cmd.eval_commit)
        begin
            held_next   = eff_held;
            stride_next = eff_stride;
            due_next    = eff_due;
            sidx_next   = (cmd.eval_bump && eff_sidx != IDX_MAX) ? eff_sidx + 32'd1
                                                                 : eff_sidx;
        end

        // Compaction step; the last one halves the count and doubles the stride
        if (cmd.cmp_write)
        begin
            if (cmp_last)
            begin
                dst_next    = '0;
                held_next   = CW'(HALF);
                stride_next = stride_dbl;
            end
            else
            begin
                dst_next = dst_reg + AW'(1);
            end
        end

        if (cmd.append)
        begin
            held_next = held_reg + CW'(1);
            due_next  = due_sat;
            sidx_next = sidx_reg + 32'd1;
        end

        if (cmd.load_result)
        begin
            value_next = rd_hit ? rdata_reg : '0;
            hit_next   = rd_hit;
            cnt_next   = held_reg;
            ostr_next  = stride_reg;
            seen_next  = sidx_reg - 32'd1;
        end
    end

    // Control and session registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rate_reg   <= RATE_RESET;
            held_reg   <= '0;
            stride_reg <= STRIDE_RESET;
            due_reg    <= INDEX_RESET;
            sidx_reg   <= INDEX_RESET;
            dst_reg    <= '0;
        end
        else
        begin
            rate_reg   <= rate_next;
            held_reg   <= held_next;
            stride_reg <= stride_next;
            due_reg    <= due_next;
            sidx_reg   <= sidx_next;
            dst_reg    <= dst_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        act_reg   <= act_next;
        first_reg <= first_next;
        speed_reg <= speed_next;
        ridx_reg  <= ridx_next;
        value_reg <= value_next;
        hit_reg   <= hit_next;
        cnt_reg   <= cnt_next;
        ostr_reg  <= ostr_next;
        seen_reg  <= seen_next;
    end

    // Point store, one write and one registered read per cycle
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[waddr] <= wdata;
        end
        if (mem_re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign entry_value  = value_reg;
    assign entry_valid  = hit_reg;
    assign point_count  = cnt_reg;
    assign stride       = ostr_reg;
    assign samples_seen = seen_reg;

`ifndef SYNTHESIS
    a_held_bound: assert property (@(posedge clk) disable iff (!rst_n)
        held_reg <= CW'(MAX_POINTS))
        else $error("point count above store size");

    a_append_room: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.append |-> (held_reg < CW'(MAX_POINTS)))
        else $error("append into a full store");

    a_stride_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.append |-> (stride_reg != 32'd0))
        else $error("zero stride at append");
`endif

endmodule
